// ----- design/integer_property_unit_top_defines.svh -----
// ----------------------------------------------------------------------------
// Integer property unit: assertion macros
// Shared assertion forms for the integer property unit.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PROPERTY_UNIT_TOP_DEFINES_SVH
`define INTEGER_PROPERTY_UNIT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ipu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ipu assertion failed");

`endif

// ----- design/ipu_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer property unit package
// Operation codes, widths and the command and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ipu_pkg;

  localparam int DataWidthDefault = 32;
  localparam int FuncWidth        = 3;
  localparam int FlagWidth        = 2;
  localparam int ValueWidth       = 35;

  // Operation codes.
  localparam logic [FuncWidth-1:0] FUNC_PARITY  = 3'd0;
  localparam logic [FuncWidth-1:0] FUNC_PRIME   = 3'd1;
  localparam logic [FuncWidth-1:0] FUNC_PALIN   = 3'd2;
  localparam logic [FuncWidth-1:0] FUNC_SIGN    = 3'd3;
  localparam logic [FuncWidth-1:0] FUNC_REVERSE = 3'd4;
  localparam logic [FuncWidth-1:0] FUNC_ADD     = 3'd5;

  // Sign class codes.
  localparam logic [FlagWidth-1:0] SIGN_ZERO = 2'd0;
  localparam logic [FlagWidth-1:0] SIGN_POS  = 2'd1;
  localparam logic [FlagWidth-1:0] SIGN_NEG  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new operation
    logic d_init;    // trial divisor starts at three
    logic d_step;    // next odd trial divisor
    logic div_start; // launch the trial divider
    logic div_rev;   // capture one tenth of the remaining magnitude
    logic rev_step;  // fold one digit into the reversal
    logic finish;    // form the result
    logic prime_ok;  // primality verdict for the finishing cycle
  } ipu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic a_le1;     // operand is at most one
    logic a_lt4;     // non-negative operand is below four
    logic a_even;
    logic sq_gt_a;   // square of trial divisor exceeds operand
    logic div_done;
    logic rem_zero;
    logic mag_zero;  // no digits left
  } ipu_stat_t;

endpackage

// ----- design/ipu_div.sv -----
// ----------------------------------------------------------------------------
// Integer property unit: divider
// Restoring unsigned divider for trial division, one bit per cycle; only
// the remainder leaves the module.
// ----------------------------------------------------------------------------
module ipu_div #(
  parameter int DATA_WIDTH = ipu_pkg::DataWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic [DATA_WIDTH-1:0] remainder_o,
  output logic                  done_o
);

  localparam int CntWidth = $clog2(DATA_WIDTH);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(DATA_WIDTH - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dsr_q, dsr_d;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_q, quo_q[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// ----- design/ipu_dp.sv -----
// ----------------------------------------------------------------------------
// Integer property unit: datapath
// Operand registers, trial divisor and its square, digit reversal and the
// result registers, around the trial divider. Decimal digits are split off
// by a reciprocal multiply.
// ----------------------------------------------------------------------------
module ipu_dp #(
  parameter int DATA_WIDTH = ipu_pkg::DataWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ipu_pkg::ipu_cmd_t                     cmd_i,
  output ipu_pkg::ipu_stat_t                    stat_o,
  input  logic [ipu_pkg::FuncWidth-1:0]         func_i,
  input  logic signed [DATA_WIDTH-1:0]          operand_a_i,
  input  logic signed [DATA_WIDTH-1:0]          operand_b_i,
  output logic [ipu_pkg::FlagWidth-1:0]         flag_o,
  output logic signed [ipu_pkg::ValueWidth-1:0] value_o
);

  localparam int VW = ipu_pkg::ValueWidth;
  localparam int SW = DATA_WIDTH + 2;
  // ceil(2^35 / 10): the top bits of n * RecipTen give n / 10 for any 32-bit n.
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;

  logic [ipu_pkg::FuncWidth-1:0] func_q;
  logic signed [DATA_WIDTH-1:0]  a_q, b_q;
  logic [DATA_WIDTH-1:0]         mag_q, mag0_q;
  logic [DATA_WIDTH-1:0]         q10_q;
  logic [DATA_WIDTH-1:0]         d_q;
  logic [SW-1:0]                 sq_q;
  logic [VW-1:0]                 rev_q;
  logic [ipu_pkg::FlagWidth-1:0] flag_q, flag_d;
  logic signed [VW-1:0]          value_q, value_d;

  logic [DATA_WIDTH-1:0] a_abs;
  logic [DATA_WIDTH-1:0] rem;
  logic [31:0]           mag32;
  logic [63:0]           ten_prod;
  logic [DATA_WIDTH-1:0] digit;
  logic                  div_done;
  logic                  neg;
  logic                  palin;

  assign a_abs = operand_a_i[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_a_i) : operand_a_i;
  assign neg   = a_q[DATA_WIDTH-1];
  assign palin = (rev_q == VW'(mag0_q));

  // Quotient by ten of the remaining magnitude, and the digit it leaves.
  assign mag32    = 32'(mag_q);
  assign ten_prod = 64'(mag32) * 64'(RecipTen);
  assign digit    = mag_q - (q10_q << 3) - (q10_q << 1);

  ipu_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (d_q),
    .remainder_o(rem),
    .done_o     (div_done)
  );

  // Operand, loop and reversal registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      mag_q  <= a_abs;
      mag0_q <= a_abs;
      rev_q  <= '0;
    end
    if (cmd_i.d_init) begin
      d_q  <= DATA_WIDTH'(3);
      sq_q <= SW'(9);
    end else if (cmd_i.d_step) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_q  <= d_q + DATA_WIDTH'(2);
      sq_q <= sq_q + {d_q, 2'b00} + SW'(4);
    end
    if (cmd_i.div_rev) begin
      q10_q <= DATA_WIDTH'(ten_prod >> 35);
    end
    if (cmd_i.rev_step) begin
      rev_q <= (rev_q << 3) + (rev_q << 1) + VW'(digit);
      mag_q <= q10_q;
    end
    if (cmd_i.finish) begin
      flag_q  <= flag_d;
      value_q <= value_d;
    end
  end

  // Result formation.
  always_comb begin
    flag_d  = '0;
    value_d = '0;
    case (func_q)
      ipu_pkg::FUNC_PARITY:  flag_d = {1'b0, a_q[0]};
      ipu_pkg::FUNC_PRIME:   flag_d = {1'b0, cmd_i.prime_ok};
      ipu_pkg::FUNC_PALIN:   flag_d = {1'b0, palin};
      ipu_pkg::FUNC_SIGN: begin
        if (neg) begin
          flag_d = ipu_pkg::SIGN_NEG;
        end else if (a_q == '0) begin
          flag_d = ipu_pkg::SIGN_ZERO;
        end else begin
          flag_d = ipu_pkg::SIGN_POS;
        end
      end
      ipu_pkg::FUNC_REVERSE: value_d = neg ? -$signed(rev_q) : $signed(rev_q);
      ipu_pkg::FUNC_ADD:     value_d = VW'(a_q) + VW'(b_q);
      default: begin
        flag_d  = '0;
        value_d = '0;
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat_o.func     = func_q;
    stat_o.a_le1    = a_q[DATA_WIDTH-1] || (a_q[DATA_WIDTH-1:1] == '0);
    stat_o.a_lt4    = (a_q[DATA_WIDTH-1:2] == '0);
    stat_o.a_even   = ~a_q[0];
    stat_o.sq_gt_a  = sq_q > SW'(a_q[DATA_WIDTH-1:0]);
    stat_o.div_done = div_done;
    stat_o.rem_zero = (rem == '0);
    stat_o.mag_zero = (mag_q == '0);
  end

  assign flag_o  = flag_q;
  assign value_o = value_q;

endmodule

// ----- design/ipu_ctrl.sv -----
// ----------------------------------------------------------------------------
// Integer property unit: controller
// Sequences dispatch, trial division and digit reversal, and raises the
// result strobe.
// ----------------------------------------------------------------------------
module ipu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               valid_o,
  input  ipu_pkg::ipu_stat_t stat_i,
  output ipu_pkg::ipu_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PR_TEST,
    ST_PR_WAIT,
    ST_RV_TEST,
    ST_RV_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = (state_q == ST_IDLE) && start;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.func)
          ipu_pkg::FUNC_PRIME: begin
            if (stat_i.a_le1) begin
              cmd_o.finish = 1'b1;
            end else if (stat_i.a_lt4) begin
              cmd_o.finish   = 1'b1;
              cmd_o.prime_ok = 1'b1;
            end else if (stat_i.a_even) begin
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.d_init = 1'b1;
              state_d      = ST_PR_TEST;
            end
          end
          ipu_pkg::FUNC_PALIN,
          ipu_pkg::FUNC_REVERSE: state_d = ST_RV_TEST;
          default: cmd_o.finish = 1'b1;
        endcase
      end
      ST_PR_TEST: begin
        if (stat_i.sq_gt_a) begin
          cmd_o.finish   = 1'b1;
          cmd_o.prime_ok = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_PR_WAIT;
        end
      end
      ST_PR_WAIT: begin
        if (stat_i.div_done) begin
          if (stat_i.rem_zero) begin
            cmd_o.finish = 1'b1;
          end else begin
            cmd_o.d_step = 1'b1;
            state_d      = ST_PR_TEST;
          end
        end
      end
      ST_RV_TEST: begin
        if (stat_i.mag_zero) begin
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.div_rev = 1'b1;
          state_d       = ST_RV_WAIT;
        end
      end
      ST_RV_WAIT: begin
        cmd_o.rev_step = 1'b1;
        state_d        = ST_RV_TEST;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.finish) begin
      state_d = ST_IDLE;
    end
    valid_d = cmd_o.finish;
  end

  // State and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;

endmodule

// ----- design/integer_property_unit_top.sv -----
// ----------------------------------------------------------------------------
// Integer property unit: top level
// Parity, primality, palindrome, sign class, digit reversal and addition
// on signed operands, one operation at a time.
// ----------------------------------------------------------------------------
// An operation is taken when start is high while busy is low. Its result
// appears on flag_o and value_o for exactly one cycle with valid_o high;
// the result cannot be held off, so a receiver must take it in that cycle.
// Parity, sign, add, unused codes and primality of operands below four or
// even finish in the dispatch state, and valid_o is registered from the finish.
// Reversal and palindrome split off one decimal digit per pass through
// the test and wait states, by a reciprocal multiply. Primality runs a
// one-bit-per-cycle divider once per odd trial divisor up to the square
// root of the operand. A new start is taken in the cycle valid_o shows.
// ----------------------------------------------------------------------------
`include "integer_property_unit_top_defines.svh"

module integer_property_unit_top #(
  parameter int DATA_WIDTH = ipu_pkg::DataWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ipu_pkg::FuncWidth-1:0]         func_i,
  input  logic signed [DATA_WIDTH-1:0]          operand_a_i,
  input  logic signed [DATA_WIDTH-1:0]          operand_b_i,
  output logic                                  valid_o,
  output logic [ipu_pkg::FlagWidth-1:0]         flag_o,
  output logic signed [ipu_pkg::ValueWidth-1:0] value_o
);

  ipu_pkg::ipu_cmd_t  cmd;
  ipu_pkg::ipu_stat_t stat;

  // Sequencer.
  ipu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .valid_o(valid_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Arithmetic and result registers.
  ipu_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .func_i     (func_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .flag_o     (flag_o),
    .value_o    (value_o)
  );

  // A result beat leaves the unit free for the next operation.
  `IPU_ASSERT_SAME(a_valid_idle, clk_i, rst_ni, valid_o, !busy)
  // The result strobe is a single-cycle pulse.
  `IPU_ASSERT_NEXT(a_valid_pulse, clk_i, rst_ni, valid_o, !valid_o)
  // An accepted operation keeps the unit busy in the next cycle.
  `IPU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // The divider only finishes while an operation is in progress.
  `IPU_ASSERT_SAME(a_div_in_op, clk_i, rst_ni, stat.div_done, busy)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer property unit testbench
// A queue of operations feeds a clocked driver that holds start until the
// unit accepts the beat. A clocked monitor compares each result beat,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DATA_WIDTH = ipu_pkg::DataWidthDefault;
  localparam int FW         = ipu_pkg::FuncWidth;
  localparam int VW         = ipu_pkg::ValueWidth;

  // Codes that the unit leaves unused.
  localparam logic [FW-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FW-1:0] FUNC_SPARE_B = 3'd7;

  typedef struct {
    logic [FW-1:0]                func;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    int unsigned                  idle;  // cycles to wait before the beat
    bit                           drain; // wait until no result is owed
  } op_item_t;

  typedef struct {
    logic [ipu_pkg::FlagWidth-1:0] flag;
    logic signed [VW-1:0]          value;
  } property_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [FW-1:0]                       func_i = '0;
  logic signed [DATA_WIDTH-1:0]        operand_a_i = '0;
  logic signed [DATA_WIDTH-1:0]        operand_b_i = '0;
  logic                                valid_o;
  logic [ipu_pkg::FlagWidth-1:0]       flag_o;
  logic signed [VW-1:0]                value_o;

  op_item_t         pending_ops[$];
  property_result_t expected_results[$];
  op_item_t         op_active;
  property_result_t oldest_result;
  bit               op_on_bus = 1'b0;
  bit               idle_armed = 1'b0;
  int unsigned      idle_left = 0;
  int unsigned      fail_count = 0;

  integer_property_unit_top #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_o),
    .flag_o      (flag_o),
    .value_o     (value_o)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decimal digit reversal that keeps the sign.
  function automatic longint reverse_decimal(longint n);
    longint mag;
    longint rev;
    bit     neg;
    neg = n < 0;
    mag = neg ? -n : n;
    rev = 0;
    while (mag != 0) begin
      rev = rev * 10 + mag % 10;
      mag = mag / 10;
    end
    return neg ? -rev : rev;
  endfunction

  // Trial division by two and then by odd divisors up to the square root.
  function automatic bit is_prime_number(longint n);
    longint d;
    if (n <= 1) return 1'b0;
    if (n < 4) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result of one operation.
  function automatic property_result_t compute_property(op_item_t op);
    property_result_t res;
    longint           a;
    longint           b;
    longint           wide;
    a = longint'(op.a);
    b = longint'(op.b);
    res.flag = '0;
    res.value = '0;
    case (op.func)
      ipu_pkg::FUNC_PARITY:  res.flag = {1'b0, op.a[0]};
      ipu_pkg::FUNC_PRIME:   res.flag = {1'b0, is_prime_number(a)};
      ipu_pkg::FUNC_PALIN:   res.flag = {1'b0, reverse_decimal(a) == a};
      ipu_pkg::FUNC_SIGN: begin
        if (a > 0) res.flag = ipu_pkg::SIGN_POS;
        else if (a < 0) res.flag = ipu_pkg::SIGN_NEG;
        else res.flag = ipu_pkg::SIGN_ZERO;
      end
      ipu_pkg::FUNC_REVERSE: begin
        wide = reverse_decimal(a);
        res.value = wide[VW-1:0];
      end
      ipu_pkg::FUNC_ADD: begin
        wide = a + b;
        res.value = wide[VW-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned random_idle();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 2);
    if (pick < 9) return $urandom_range(3, 10);
    return $urandom_range(30, 200);
  endfunction

  // Operand for a random operation. Primality operands are small, negative
  // or have a factor of two or three, so that trial division ends quickly.
  function automatic logic signed [DATA_WIDTH-1:0] random_operand(logic [FW-1:0] func);
    logic signed [DATA_WIDTH-1:0] opnd;
    int unsigned                  pick;
    longint                       pal;
    pick = $urandom_range(0, 9);
    opnd = DATA_WIDTH'($urandom);
    case (func)
      ipu_pkg::FUNC_PRIME: begin
        if (pick < 7) opnd = DATA_WIDTH'($urandom_range(0, 100000));
        else if (pick < 8) opnd[DATA_WIDTH-1] = 1'b1;
        else if (pick < 9) opnd = DATA_WIDTH'(3 * $urandom_range(1, 715827882));
        else opnd = DATA_WIDTH'({$urandom_range(0, 32'h3FFF_FFFF), 1'b0});
      end
      ipu_pkg::FUNC_PALIN: begin
        if (pick < 6) begin
          pal = longint'($urandom_range(1, 9999));
          pal = pal * ((pal < 10) ? 10 : (pal < 100) ? 100 : (pal < 1000) ? 1000 : 10000)
                + reverse_decimal(pal);
          opnd = (pick < 3) ? pal[DATA_WIDTH-1:0] : -pal[DATA_WIDTH-1:0];
        end
      end
      default: begin
        if (pick < 3) begin
          opnd = DATA_WIDTH'($urandom_range(0, 999));
          if (pick == 0) opnd = -opnd;
        end
      end
    endcase
    return opnd;
  endfunction

  task automatic queue_op(input logic [FW-1:0] func,
                          input logic signed [DATA_WIDTH-1:0] a,
                          input logic signed [DATA_WIDTH-1:0] b,
                          input int unsigned idle, input bit drain);
    op_item_t op;
    op.func = func;
    op.a = a;
    op.b = b;
    op.idle = idle;
    op.drain = drain;
    pending_ops.push_back(op);
  endtask

  // Driver: records each accepted beat, then holds the next operation on
  // the bus after its gap. Between operations the data ports carry noise.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(compute_property(op_active));
        op_on_bus = 1'b0;
      end
      if (!op_on_bus && pending_ops.size() != 0) begin
        if (!idle_armed) begin
          idle_left = pending_ops[0].idle;
          idle_armed = 1'b1;
        end
        if (idle_left != 0) begin
          idle_left--;
        end else if (!pending_ops[0].drain || expected_results.size() == 0) begin
          op_active = pending_ops.pop_front();
          op_on_bus = 1'b1;
          idle_armed = 1'b0;
        end
      end
      start <= op_on_bus;
      if (op_on_bus) begin
        func_i      <= op_active.func;
        operand_a_i <= op_active.a;
        operand_b_i <= op_active.b;
      end else begin
        func_i      <= FW'($urandom);
        operand_a_i <= DATA_WIDTH'($urandom);
        operand_b_i <= DATA_WIDTH'($urandom);
      end
    end
  end

  // Monitor: every result beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no operation pending: flag %0d value %0d", flag_o, value_o);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (flag_o !== oldest_result.flag) begin
          $error("flag: expected %0d, actual %0d", oldest_result.flag, flag_o);
          fail_count++;
        end
        if (value_o !== oldest_result.value) begin
          $error("value: expected %0d, actual %0d", oldest_result.value, value_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [FW-1:0] func;
    // Parity at the extremes.
    queue_op(ipu_pkg::FUNC_PARITY, -1, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PARITY, 32'h7FFF_FFFF, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PARITY, 32'h8000_0000, $urandom, random_idle(), 1'b0);
    // Primality: values at or below one, the smallest prime, a small even
    // composite, a large prime and a large composite.
    queue_op(ipu_pkg::FUNC_PRIME, 0, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, 1, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, 2, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, 4, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, -7, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, 1000003, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PRIME, 32'h7FFF_FFFD, $urandom, random_idle(), 1'b0);
    // Palindromes, a negative one among them, and a non-palindrome.
    queue_op(ipu_pkg::FUNC_PALIN, 12321, $urandom, random_idle(), 1'b1);
    queue_op(ipu_pkg::FUNC_PALIN, -121, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_PALIN, 10, $urandom, random_idle(), 1'b0);
    // Sign classes.
    queue_op(ipu_pkg::FUNC_SIGN, 0, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_SIGN, 5, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_SIGN, 32'h8000_0000, $urandom, random_idle(), 1'b0);
    // Reversal with trailing zeros, of the most negative and of the largest operand.
    queue_op(ipu_pkg::FUNC_REVERSE, 1200, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_REVERSE, 32'h8000_0000, $urandom, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_REVERSE, 32'h7FFF_FFFF, $urandom, random_idle(), 1'b0);
    // Sums at the extremes.
    queue_op(ipu_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_ADD, 32'h8000_0000, 32'h8000_0000, random_idle(), 1'b0);
    queue_op(ipu_pkg::FUNC_ADD, -1, 1, random_idle(), 1'b0);
    // Unused codes.
    queue_op(FUNC_SPARE_A, $urandom, $urandom, random_idle(), 1'b0);
    queue_op(FUNC_SPARE_B, $urandom, $urandom, random_idle(), 1'b0);
    // Random operations, with one stretch that has no gaps at all.
    for (int i = 0; i < 76; i++) begin
      func = FW'($urandom_range(0, 7));
      queue_op(func, random_operand(func), $urandom,
               (i >= 30 && i < 50) ? 0 : random_idle(), i == 60);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_ops.size() != 0 || op_on_bus || expected_results.size() != 0);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
